// ===== rtl/dtrp_pkg.sv =====
// Types and codes shared by the device table record parser.
`timescale 1ns / 1ps
package dtrp_pkg;

  localparam int unsigned NameTextW = 64;

  typedef enum logic [1:0] {
    KIND_NODE_NAME = 2'd0,
    KIND_RECORD    = 2'd1,
    KIND_END       = 2'd2
  } item_kind_e;

  typedef enum logic [5:0] {
    PH_NODE_NAME = 6'b000001,
    PH_TYPE      = 6'b000010,
    PH_ATTR      = 6'b000100,
    PH_UID       = 6'b001000,
    PH_DEV_NAME  = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_e;

endpackage

// ===== rtl/device_table_record_parser_top.sv =====
// Device table record parser: header skip, node name, device records, end of table.
`timescale 1ns / 1ps
// Output: a result is registered and appears on the master side in the cycle after the byte that ends it.
// Throughput: one byte per cycle; the byte is parsed in the cycle it is accepted and the
// result is held in one output register, so input stalls only while that register is full
// and not taken.
// Reset: rst_ni clears the parser to the start of a packet; the parser also returns there
// after each byte flagged tlast.
module device_table_record_parser_top #(
  parameter int unsigned HEADER_BYTES = 8,
  parameter int unsigned NAME_BYTES   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // last_in_packet
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // [7:0] device_type, [15:8] device_attr,
                                        // [23:16] device_uid, [87:24] name_text
  output dtrp_pkg::item_kind_e m_axis_tuser_o  // [1:0] item_kind
);
  import dtrp_pkg::*;

  localparam int unsigned PosW  = $clog2(HEADER_BYTES + 1);
  localparam int unsigned IdxW  = $clog2(NAME_BYTES + 1);
  localparam int unsigned NameW = 8 * NAME_BYTES;

  logic [PosW-1:0]  hdr_q, hdr_d;
  phase_e           phase_q, phase_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [NameW-1:0] name_q, name_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       attr_q, attr_d;
  logic [7:0]       uid_q, uid_d;

  logic             m_valid_q;
  item_kind_e       m_kind_q, kind_d;
  logic [7:0]       m_type_q, m_attr_q, m_uid_q;
  logic [NameW-1:0] m_name_q, out_name_d;

  logic             acc;
  logic             emit;
  logic             in_header;
  logic [IdxW-1:0]  idx_take;
  logic [NameW-1:0] name_take;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign acc       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_header = hdr_q < PosW'(HEADER_BYTES);

  // Store the byte into the next free name slot; drop it once the slots are used up.
  always_comb begin
    name_take = name_q;
    idx_take  = idx_q;
    if (idx_q < IdxW'(NAME_BYTES)) begin
      for (int unsigned j = 0; j < NAME_BYTES; j++) begin
        if (idx_q == IdxW'(j)) begin
          name_take[8*j +: 8] = s_axis_tdata_i;
        end
      end
      idx_take = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    hdr_d      = hdr_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    name_d     = name_q;
    type_d     = type_q;
    attr_d     = attr_q;
    uid_d      = uid_q;
    emit       = 1'b0;
    kind_d     = KIND_END;
    out_name_d = name_take;
    if (phase_q == PH_DONE) begin
      // ignore the rest of the packet
    end else if (in_header) begin
      hdr_d = hdr_q + PosW'(1);
    end else begin
      unique case (phase_q)
        PH_NODE_NAME, PH_DEV_NAME: begin
          if (s_axis_tdata_i == 8'd0) begin
            emit    = 1'b1;
            kind_d  = (phase_q == PH_NODE_NAME) ? KIND_NODE_NAME : KIND_RECORD;
            name_d  = '0;
            idx_d   = '0;
            phase_d = PH_TYPE;
          end else begin
            name_d = name_take;
            idx_d  = idx_take;
          end
        end
        PH_ATTR: begin
          attr_d  = s_axis_tdata_i;
          phase_d = PH_UID;
        end
        PH_UID: begin
          uid_d   = s_axis_tdata_i;
          idx_d   = '0;
          name_d  = '0;
          phase_d = PH_DEV_NAME;
        end
        default: begin
          if (s_axis_tdata_i == 8'd0) begin
            emit       = 1'b1;
            kind_d     = KIND_END;
            out_name_d = '0;
            phase_d    = PH_DONE;
          end else begin
            type_d  = s_axis_tdata_i;
            phase_d = PH_ATTR;
          end
        end
      endcase
    end
    // Restart at the packet boundary.
    if (s_axis_tlast_i) begin
      hdr_d   = '0;
      phase_d = PH_NODE_NAME;
      idx_d   = '0;
      name_d  = '0;
      type_d  = '0;
      attr_d  = '0;
      uid_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= '0;
      phase_q <= PH_NODE_NAME;
      idx_q   <= '0;
      name_q  <= '0;
      type_q  <= '0;
      attr_q  <= '0;
      uid_q   <= '0;
    end else if (acc) begin
      hdr_q   <= hdr_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      name_q  <= name_d;
      type_q  <= type_d;
      attr_q  <= attr_d;
      uid_q   <= uid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (acc) begin
      m_valid_q <= emit;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && emit) begin
      m_kind_q <= kind_d;
      m_type_q <= (kind_d == KIND_RECORD) ? type_q : 8'd0;
      m_attr_q <= (kind_d == KIND_RECORD) ? attr_q : 8'd0;
      m_uid_q  <= (kind_d == KIND_RECORD) ? uid_q : 8'd0;
      m_name_q <= out_name_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tdata_o  = {NameTextW'(m_name_q), m_uid_q, m_attr_q, m_type_q};

  a_last_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast_i) |=> (phase_q == PH_NODE_NAME && hdr_q == '0 && idx_q == '0))
    else $error("parser did not restart after last byte");

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(NAME_BYTES))
    else $error("name index beyond name slots");

  a_emit_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && emit) |=> m_valid_q)
    else $error("result lost");

  a_header_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_header) |=> !m_valid_q)
    else $error("result during header");

endmodule
